/* rtl/hsfd_pkg.sv */
// Shared types, constants and CRC helper for the humidity sensor frame decoder.
`default_nettype none

package hsfd_pkg;

   typedef logic [2:0] hsfd_pos_type;

   // Byte positions within one six-byte frame
   localparam hsfd_pos_type POS_TEMP_HI = 3'd0;
   localparam hsfd_pos_type POS_TEMP_LO = 3'd1;
   localparam hsfd_pos_type POS_TEMP_CRC = 3'd2;
   localparam hsfd_pos_type POS_HUM_HI = 3'd3;
   localparam hsfd_pos_type POS_HUM_LO = 3'd4;
   localparam hsfd_pos_type POS_HUM_CRC = 3'd5;

   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   localparam logic [10:0] OFFSET_RESET = 11'd400;
   localparam logic [14:0] TEMP_SCALE = 15'd17500;
   localparam logic [13:0] HUM_SCALE = 14'd10000;
   localparam logic signed [15:0] TEMP_BIAS = 16'sd4500;

   // Status bits
   localparam int STATUS_TEMP_BAD = 0;
   localparam int STATUS_HUM_BAD = 1;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } hsfd_req_type;

   typedef struct packed {
      logic signed [14:0] temperature_centi;
      logic [13:0]        humidity_centi;
      logic [1:0]         crc_status;
   } hsfd_rsp_type;

   // Completed raw frame handed from the assembler to the converter
   typedef struct packed {
      logic        valid;
      logic [15:0] temp_raw;
      logic [15:0] hum_raw;
      logic [1:0]  crc_status;
   } hsfd_frame_type;

   // CRC-8, MSB first, no reflection, no final xor
   function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/humidity_sensor_frame_decoder.sv */
// Top level of the humidity sensor frame decoder.
// Two register stages: the sixth byte's transfer loads the frame register, and the
// frame moves on into the result register when that register is empty or being drained.
// Throughput: one byte per cycle while req_stall is low; one result per six bytes.
// The frame register and the result register form a two-entry pipeline, so the
// input stalls only when both hold a frame and the result side stalls.
// Reset (synchronous, active high): position 0, CRC 0xFF, offset 400, no result.
`default_nettype none

module humidity_sensor_frame_decoder
   import hsfd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire hsfd_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output hsfd_rsp_type      rsp_data,
   input  wire logic         csr_wr_en,
   input  wire logic [10:0]  csr_wr_data
);

   logic [10:0]    offset_ff;
   hsfd_frame_type frame;
   logic           rsp_free;
   logic           req_xfer;
   logic           rsp_xfer;
   logic           advance;

   // Offset register; the user must write it only while the block is idle (not enforced here)
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
      end else if (csr_wr_en) begin
         offset_ff <= csr_wr_data;
      end
   end

   // Result register can take a new value when empty or being drained
   assign rsp_xfer = rsp_valid & ~rsp_stall;
   assign rsp_free = ~rsp_valid | ~rsp_stall;

   // Advance a finished frame into the result register
   assign advance = frame.valid & rsp_free;

   // Hold bytes only when a finished frame cannot move on
   assign req_stall = frame.valid & ~rsp_free;
   assign req_xfer  = req_valid & ~req_stall;

   hsfd_frame u_frame (
      .clock  (clock),
      .reset  (reset),
      .accept (req_xfer),
      .item   (req_data),
      .drain  (advance),
      .frame  (frame)
   );

   hsfd_convert u_convert (
      .clock     (clock),
      .reset     (reset),
      .frame     (frame),
      .load      (advance),
      .unload    (rsp_xfer),
      .offset    (offset_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* rtl/hsfd_frame.sv */
// Frame assembler: byte position, running CRC and raw word capture.
`default_nettype none

module hsfd_frame
   import hsfd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire hsfd_req_type   item,
   input  wire logic           drain,
   output hsfd_frame_type      frame
);

   hsfd_pos_type   pos_ff, pos_in;
   logic [7:0]     crc_ff, crc_in;
   logic [15:0]    temp_word_ff, temp_word_in;
   logic [15:0]    hum_word_ff, hum_word_in;
   logic           temp_good_ff, temp_good_in;
   hsfd_frame_type frame_ff, frame_in;

   hsfd_pos_type   pos;
   logic [7:0]     crc;
   logic [7:0]     crc_next;

   always_comb begin
      // Start mark or stray position restarts the frame
      if (item.frame_start || pos_ff > POS_HUM_CRC) begin
         pos = POS_TEMP_HI;
         crc = CRC_INIT;
      end else begin
         pos = pos_ff;
         crc = crc_ff;
      end
      crc_next = crc8_feed(crc, item.rx_byte);

      pos_in       = pos_ff;
      crc_in       = crc_ff;
      temp_word_in = temp_word_ff;
      hum_word_in  = hum_word_ff;
      temp_good_in = temp_good_ff;
      frame_in     = frame_ff;
      if (drain) begin
         frame_in.valid = 1'b0;
      end

      if (accept) begin
         pos_in = pos + 3'd1;
         case (pos)
            POS_TEMP_HI: begin
               crc_in       = crc8_feed(CRC_INIT, item.rx_byte);
               temp_word_in = {item.rx_byte, 8'h00};
            end
            POS_TEMP_LO: begin
               crc_in       = crc_next;
               temp_word_in = {temp_word_ff[15:8], item.rx_byte};
            end
            POS_TEMP_CRC: begin
               temp_good_in = (crc == item.rx_byte);
               crc_in       = CRC_INIT;
            end
            POS_HUM_HI: begin
               crc_in      = crc8_feed(CRC_INIT, item.rx_byte);
               hum_word_in = {item.rx_byte, 8'h00};
            end
            POS_HUM_LO: begin
               crc_in      = crc_next;
               hum_word_in = {hum_word_ff[15:8], item.rx_byte};
            end
            default: begin
               // Last byte: hand the frame on and wrap
               frame_in.valid                       = 1'b1;
               frame_in.temp_raw                    = temp_word_ff;
               frame_in.hum_raw                     = hum_word_ff;
               frame_in.crc_status[STATUS_TEMP_BAD] = ~temp_good_ff;
               frame_in.crc_status[STATUS_HUM_BAD]  = (crc != item.rx_byte);
               pos_in                               = POS_TEMP_HI;
               crc_in                               = CRC_INIT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= POS_TEMP_HI;
         crc_ff         <= CRC_INIT;
         temp_word_ff   <= 16'h0000;
         hum_word_ff    <= 16'h0000;
         temp_good_ff   <= 1'b0;
         frame_ff.valid <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         crc_ff         <= crc_in;
         temp_word_ff   <= temp_word_in;
         hum_word_ff    <= hum_word_in;
         temp_good_ff   <= temp_good_in;
         frame_ff       <= frame_in;
      end
   end

   assign frame = frame_ff;

endmodule

`default_nettype wire

/* rtl/hsfd_convert.sv */
// Converter: raw words to centi-units and the result register.
`default_nettype none

module hsfd_convert
   import hsfd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire hsfd_frame_type frame,
   input  wire logic           load,
   input  wire logic           unload,
   input  wire logic [10:0]    offset,
   output logic                rsp_valid,
   output hsfd_rsp_type        rsp_data
);

   logic [30:0]        temp_prod;
   logic [29:0]        hum_prod;
   logic signed [15:0] temp_full;
   logic               valid_ff, valid_in;
   hsfd_rsp_type       data_ff, data_in;

   assign temp_prod = TEMP_SCALE * frame.temp_raw;
   assign hum_prod  = HUM_SCALE * frame.hum_raw;
   assign temp_full = $signed({1'b0, temp_prod[30:16]}) - TEMP_BIAS
                      - $signed({5'b00000, offset});

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (unload) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in                  = 1'b1;
         data_in.temperature_centi = temp_full[14:0];
         data_in.humidity_centi    = hum_prod[29:16];
         data_in.crc_status        = frame.crc_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

/* rtl/hsfd_checker.sv */
// Port-level checker for the humidity sensor frame decoder, with its bind.
`default_nettype none

module hsfd_checker
   import hsfd_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire hsfd_req_type req_data,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire hsfd_rsp_type rsp_data
);

   // Hold a stalled byte
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled byte changed");

   // Hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Humidity scaling stays below full scale
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.humidity_centi <= 14'd9999)
      else $error("humidity out of range");

   // Temperature stays within scaled range less the largest offset
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_data.temperature_centi) >= -16'sd6547)
                 && ($signed(rsp_data.temperature_centi) <= 16'sd13000))
      else $error("temperature out of range");

   // Drop any result on reset, and do not stall the input just after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("state not cleared by reset");

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* dv/hsfd_checker.sv */
// Scoreboard for the sensor frame decoder: predicts each result from transfers and compares.
`timescale 1ns / 100ps

module hsfd_scoreboard
   import hsfd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_stall,
   input  wire hsfd_req_type req_data,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_stall,
   input  wire hsfd_rsp_type rsp_data,
   input  wire logic         csr_wr_en,
   input  wire logic [10:0]  csr_wr_data,
   output int                mismatch_count,
   output int                results_pending
);

   logic [2:0]   frame_pos;
   logic [7:0]   word_crc;
   logic [15:0]  temp_word;
   logic [15:0]  hum_word;
   logic         temp_crc_ok;
   logic [10:0]  board_offset;
   hsfd_rsp_type decoded_q[$];
   int           errors = 0;

   function automatic logic [7:0] crc_add_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      repeat (8) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ 8'h31) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   // Advance the frame assembler by one received byte; queue a result after the last byte.
   task automatic decode_byte(input hsfd_req_type item);
      logic [2:0]   pos;
      logic [7:0]   crc;
      logic [31:0]  temp_scaled;
      logic [31:0]  hum_scaled;
      int           temp_centi;
      hsfd_rsp_type result;
      pos = frame_pos;
      crc = word_crc;
      if (item.frame_start || pos > POS_HUM_CRC) begin
         pos = POS_TEMP_HI;
         crc = CRC_INIT;
      end
      case (pos)
         POS_TEMP_HI: begin
            crc = crc_add_byte(CRC_INIT, item.rx_byte);
            temp_word = {item.rx_byte, 8'h00};
         end
         POS_TEMP_LO: begin
            crc = crc_add_byte(crc, item.rx_byte);
            temp_word[7:0] = item.rx_byte;
         end
         POS_TEMP_CRC: begin
            temp_crc_ok = (crc == item.rx_byte);
            crc = CRC_INIT;
         end
         POS_HUM_HI: begin
            crc = crc_add_byte(CRC_INIT, item.rx_byte);
            hum_word = {item.rx_byte, 8'h00};
         end
         POS_HUM_LO: begin
            crc = crc_add_byte(crc, item.rx_byte);
            hum_word[7:0] = item.rx_byte;
         end
         default: begin
            temp_scaled = (32'd17500 * {16'd0, temp_word}) >> 16;
            hum_scaled = (32'd10000 * {16'd0, hum_word}) >> 16;
            temp_centi = int'(temp_scaled) - 4500 - int'({21'd0, board_offset});
            result.temperature_centi = temp_centi[14:0];
            result.humidity_centi = hum_scaled[13:0];
            result.crc_status = 2'b00;
            result.crc_status[STATUS_TEMP_BAD] = !temp_crc_ok;
            result.crc_status[STATUS_HUM_BAD] = (crc != item.rx_byte);
            decoded_q.push_back(result);
            crc = CRC_INIT;
         end
      endcase
      frame_pos = (pos == POS_HUM_CRC) ? POS_TEMP_HI : pos + 3'd1;
      word_crc = crc;
   endtask

   task automatic check_result(input hsfd_rsp_type actual);
      hsfd_rsp_type want;
      if (decoded_q.size() == 0) begin
         $error("result transfer with no result expected");
         errors++;
      end else begin
         want = decoded_q.pop_front();
         if (actual.temperature_centi !== want.temperature_centi) begin
            $error("temperature_centi: expected %0d, actual %0d",
                   $signed(want.temperature_centi), $signed(actual.temperature_centi));
            errors++;
         end
         if (actual.humidity_centi !== want.humidity_centi) begin
            $error("humidity_centi: expected %0d, actual %0d",
                   want.humidity_centi, actual.humidity_centi);
            errors++;
         end
         if (actual.crc_status !== want.crc_status) begin
            $error("crc_status: expected %0d, actual %0d", want.crc_status, actual.crc_status);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_pos = POS_TEMP_HI;
         word_crc = CRC_INIT;
         temp_word = 16'd0;
         hum_word = 16'd0;
         temp_crc_ok = 1'b0;
         board_offset = OFFSET_RESET;
         decoded_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_result(rsp_data);
         end
         if (req_valid && !req_stall) begin
            decode_byte(req_data);
         end
         if (csr_wr_en) begin
            board_offset = csr_wr_data;
         end
      end
      mismatch_count <= errors;
      results_pending <= decoded_q.size();
   end

endmodule

/* dv/humidity_sensor_frame_decoder_test.sv */
// Testbench top for the sensor frame decoder: stimulus, result-side stalls, watchdog and verdict.
`timescale 1ns / 100ps

module humidity_sensor_frame_decoder_test;
   import hsfd_pkg::*;

   // Cycles without any transfer before the run is declared hung
   localparam int IDLE_LIMIT = 2000;
   localparam int PHASE_BYTES = 100;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   hsfd_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   hsfd_rsp_type rsp_data;
   logic         csr_wr_en;
   logic [10:0]  csr_wr_data;

   int           mismatch_count;
   int           results_pending;
   int           bytes_sent = 0;
   int           idle_cycles = 0;
   // When set, neither side inserts gaps or stalls
   bit           burst = 1'b0;

   always #5 clock = ~clock;

   humidity_sensor_frame_decoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   hsfd_scoreboard i_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   // CRC-8 over one 16-bit word, bit-serial, MSB first; used to build each frame's CRC bytes
   function automatic logic [7:0] word_crc(input logic [15:0] word);
      logic [7:0] c;
      c = CRC_INIT;
      for (int i = 15; i >= 0; i--) begin
         c = {c[6:0], 1'b0} ^ ((c[7] ^ word[i]) ? CRC_POLY : 8'h00);
      end
      return c;
   endfunction

   // Pick a raw sensor word, biased toward the extremes of the range
   function automatic logic [15:0] pick_raw();
      case ($urandom_range(0, 7))
         0: begin
            return 16'h0000;
         end
         1: begin
            return 16'hFFFF;
         end
         default: begin
            return 16'($urandom_range(0, 16'hFFFF));
         end
      endcase
   endfunction

   // Present one byte after a random gap (none in burst mode), then hold it until the transfer happens
   task automatic send_byte(input logic [7:0] value, input logic start);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{rx_byte: value, frame_start: start};
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // Send a full six-byte frame; a bad CRC is the good one with some bits flipped
   task automatic send_frame(input logic [15:0] temp_raw, input logic [15:0] hum_raw,
                             input bit temp_good, input bit hum_good, input logic start);
      logic [7:0] temp_crc;
      logic [7:0] hum_crc;
      temp_crc = word_crc(temp_raw) ^ (temp_good ? 8'h00 : 8'($urandom_range(1, 255)));
      hum_crc = word_crc(hum_raw) ^ (hum_good ? 8'h00 : 8'($urandom_range(1, 255)));
      send_byte(temp_raw[15:8], start);
      send_byte(temp_raw[7:0], 1'b0);
      send_byte(temp_crc, 1'b0);
      send_byte(hum_raw[15:8], 1'b0);
      send_byte(hum_raw[7:0], 1'b0);
      send_byte(hum_crc, 1'b0);
   endtask

   // Drain every expected result, then let the pipeline settle before touching the register
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_offset(input logic [10:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Result side: draw a stall for every result, then release and wait for the transfer
   initial begin
      int hold;
      rsp_stall = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         hold = burst ? 0 : $urandom_range(0, 8);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // Watchdog: count cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      logic [10:0] phase_offset[6];
      bit          need_sync;
      int          kind;
      int          target;
      int          run_len;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames under the reset offset.
      // All-zero words with good CRCs: lowest temperature and humidity.
      send_frame(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1);
      // Full-scale words, humidity CRC wrong: status reports humidity only.
      send_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b1);
      // Drop a partial frame: a start mark mid-frame must resynchronize.
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_frame(16'h8000, 16'h1234, 1'b0, 1'b1, 1'b1);
      // Back to back with no start mark, both CRCs bad; values still reported.
      send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);

      // Offsets per phase: both extremes, beyond the documented range, random, reset value
      phase_offset[0] = 11'd0;
      phase_offset[1] = 11'd2000;
      phase_offset[2] = 11'h7FF;
      phase_offset[3] = 11'($urandom_range(0, 2000));
      phase_offset[4] = 11'($urandom_range(0, 2047));
      phase_offset[5] = OFFSET_RESET;

      need_sync = 1'b0;
      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         write_offset(phase_offset[phase]);
         // Run one phase with no gaps and no stalls at all
         burst = (phase == 2);
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) begin
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
               // Well-formed frame; force a start mark after any broken sequence
               send_frame(pick_raw(), pick_raw(), $urandom_range(0, 5) != 0,
                          $urandom_range(0, 5) != 0, need_sync || ($urandom_range(0, 1) == 1));
               need_sync = 1'b0;
            end else if (kind == 8) begin
               // Truncated frame with random start marks
               run_len = $urandom_range(1, 5);
               repeat (run_len) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               need_sync = 1'b1;
            end else begin
               // Stray byte
               send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               need_sync = 1'b1;
            end
         end
      end
      burst = 1'b0;

      // Drain, then allow for latency plus the longest stall
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/hsfd_pkg.sv
rtl/hsfd_frame.sv
rtl/hsfd_convert.sv
rtl/humidity_sensor_frame_decoder.sv
rtl/hsfd_checker.sv
dv/hsfd_checker.sv
dv/humidity_sensor_frame_decoder_test.sv
